// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, coordinate types and stage-advance struct for the
// point-in-prism pipeline.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int CoordBits = 16;
  localparam int CornerW   = 3 * CoordBits;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int CrossW    = ProdW + 1;
  localparam int DotW      = DiffW + CrossW;
  localparam int SumW      = DotW + 2;
  localparam int CfgIdxW   = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCornerZero  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCornerOne   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCornerTwo   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCornerThree = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;
  typedef logic signed [ProdW-1:0]     prod_t;
  typedef logic signed [CrossW-1:0]    cross_t;
  typedef logic signed [DotW-1:0]      dot_t;
  typedef logic signed [SumW-1:0]      sum_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } corner_t;

  typedef struct packed {
    diff_t z;
    diff_t y;
    diff_t x;
  } vec_t;

  // load enables for the stages inside a face unit
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pip_adv_t;

endpackage

// File: rtl/pip_face_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_face_det
// Four-stage sign test of det(r0, r1, r2) = r0 . (r1 x r2): partial products,
// cross product, dot-product terms, then sum and strict-positive flag.
// ----------------------------------------------------------------------------
module pip_face_det (
  input  logic             clk_i,
  input  pip_pkg::pip_adv_t adv_i,
  input  pip_pkg::vec_t    r0_i,
  input  pip_pkg::vec_t    r1_i,
  input  pip_pkg::vec_t    r2_i,
  output logic             pos_o
);
  import pip_pkg::*;

  prod_t  pr_d [6];
  prod_t  pr_q [6];
  vec_t   r0_s2_q, r0_s3_q;
  cross_t cr_d [3];
  cross_t cr_q [3];
  dot_t   dt_d [3];
  dot_t   dt_q [3];
  sum_t   sum;
  logic   pos_q;

  // stage 2: six partial products of the cross product
  assign pr_d[0] = r1_i.y * r2_i.z;
  assign pr_d[1] = r1_i.z * r2_i.y;
  assign pr_d[2] = r1_i.z * r2_i.x;
  assign pr_d[3] = r1_i.x * r2_i.z;
  assign pr_d[4] = r1_i.x * r2_i.y;
  assign pr_d[5] = r1_i.y * r2_i.x;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pr_q    <= pr_d;
      r0_s2_q <= r0_i;
    end
  end

  // stage 3: cross product components
  assign cr_d[0] = cross_t'(pr_q[0]) - cross_t'(pr_q[1]);
  assign cr_d[1] = cross_t'(pr_q[2]) - cross_t'(pr_q[3]);
  assign cr_d[2] = cross_t'(pr_q[4]) - cross_t'(pr_q[5]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      cr_q    <= cr_d;
      r0_s3_q <= r0_s2_q;
    end
  end

  // stage 4: dot-product terms
  assign dt_d[0] = r0_s3_q.x * cr_q[0];
  assign dt_d[1] = r0_s3_q.y * cr_q[1];
  assign dt_d[2] = r0_s3_q.z * cr_q[2];

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      dt_q <= dt_d;
    end
  end

  // stage 5: exact sum, strictly positive only
  assign sum = sum_t'(dt_q[0]) + sum_t'(dt_q[1]) + sum_t'(dt_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      pos_q <= !sum[SumW-1] && (sum != '0);
    end
  end

  assign pos_o = pos_q;

endmodule

// File: rtl/point_in_prism_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_prism_test
// Strict point-in-triangular-prism test: five face determinants computed
// exactly, the point is inside only when all five are positive.
// ----------------------------------------------------------------------------
// throughput: one point per cycle unless the pipeline stalls; six register
//   stages (differences, products, cross, dot terms, sum sign, output) each
//   advance on their own
// stalls fill bubbles first; the input stalls only once all six stages are full
// reset clears all valid bits and the four corner registers to zero
module point_in_prism_test (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pip_pkg::CornerW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [pip_pkg::CoordBits-1:0] point_x_i,
  input  logic signed [pip_pkg::CoordBits-1:0] point_y_i,
  input  logic signed [pip_pkg::CoordBits-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o
);
  import pip_pkg::*;

  corner_t  p0_q, p1_q, p2_q, p3_q;
  logic     v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic     en1, en2, en3, en4, en5, en_out;
  pip_adv_t adv;
  vec_t     q0_q, q1_q, q3_q, e01_q, e02_q, e03_q, e10_q, e13_q, e12_q;
  logic     [4:0] pos;
  logic     inside_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCornerZero:  p0_q <= cfg_data_i;
        CfgCornerOne:   p1_q <= cfg_data_i;
        CfgCornerTwo:   p2_q <= cfg_data_i;
        CfgCornerThree: p3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-stage advance, bubbles get filled
  assign en_out = !out_valid_q || !out_stall_i;
  assign en5    = !v5_q || en_out;
  assign en4    = !v4_q || en5;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign in_stall_o = !en1;
  assign adv = '{s2: en2, s3: en3, s4: en4, s5: en5};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= in_valid_i;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en5)    v5_q        <= v4_q;
      if (en_out) out_valid_q <= v5_q;
    end
  end

  function automatic vec_t vsub(input corner_t a, input corner_t b);
    vec_t r;
    r.x = diff_t'(a.x) - diff_t'(b.x);
    r.y = diff_t'(a.y) - diff_t'(b.y);
    r.z = diff_t'(a.z) - diff_t'(b.z);
    return r;
  endfunction

  // stage 1: difference vectors
  always_ff @(posedge clk_i) begin
    if (en1) begin
      q0_q  <= vsub('{z: point_z_i, y: point_y_i, x: point_x_i}, p0_q);
      q1_q  <= vsub('{z: point_z_i, y: point_y_i, x: point_x_i}, p1_q);
      q3_q  <= vsub('{z: point_z_i, y: point_y_i, x: point_x_i}, p3_q);
      e01_q <= vsub(p1_q, p0_q);
      e02_q <= vsub(p2_q, p0_q);
      e03_q <= vsub(p3_q, p0_q);
      e10_q <= vsub(p0_q, p1_q);
      e13_q <= vsub(p3_q, p1_q);
      e12_q <= vsub(p2_q, p1_q);
    end
  end

  // bottom, top, and the three side faces
  pip_face_det u_bottom (
    .clk_i (clk_i), .adv_i (adv),
    .r0_i (q0_q), .r1_i (e01_q), .r2_i (e02_q), .pos_o (pos[0])
  );
  pip_face_det u_top (
    .clk_i (clk_i), .adv_i (adv),
    .r0_i (q3_q), .r1_i (e02_q), .r2_i (e01_q), .pos_o (pos[1])
  );
  pip_face_det u_side_a (
    .clk_i (clk_i), .adv_i (adv),
    .r0_i (q1_q), .r1_i (e10_q), .r2_i (e13_q), .pos_o (pos[2])
  );
  pip_face_det u_side_b (
    .clk_i (clk_i), .adv_i (adv),
    .r0_i (q0_q), .r1_i (e02_q), .r2_i (e03_q), .pos_o (pos[3])
  );
  pip_face_det u_side_c (
    .clk_i (clk_i), .adv_i (adv),
    .r0_i (q1_q), .r1_i (e03_q), .r2_i (e12_q), .pos_o (pos[4])
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      inside_q <= &pos;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule
